### hw/rtl/frbs_pkg.sv
package frbs_pkg;

	// field widths
	localparam int unsigned POS_W   = 17;
	localparam int unsigned CNT_W   = 17;
	localparam int unsigned BLK_W   = 16;
	localparam int unsigned OFF_W   = 12;
	localparam int unsigned LEN_W   = 13;
	localparam int unsigned BS_W    = 13;
	localparam int unsigned IDX_W   = 4;

	// quotient bits of position / block size, block size is at least 16
	localparam int unsigned QUO_W   = 13;

	// block size limits and reset value
	localparam logic [BS_W-1:0] BS_MIN   = 13'd16;
	localparam logic [BS_W-1:0] BS_MAX   = 13'd4096;
	localparam logic [BS_W-1:0] BS_RESET = 13'd64;

	localparam int unsigned TABLE_ENTRIES_DEF = 16;

	// operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_MAP  = 1'b1;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_PREP,
		ST_EMIT,
		ST_ERR
	} state_t;

	// clamp a written block size into the supported range
	function automatic logic [BS_W-1:0] clamp_bs(input logic [BS_W-1:0] v);
		logic [BS_W-1:0] r;
		r = v;
		if (v < BS_MIN) r = BS_MIN;
		if (v > BS_MAX) r = BS_MAX;
		return r;
	endfunction

endpackage

### hw/rtl/file_range_block_segmenter_unit.sv
// File range block segmenter.
// Splits a byte range of a file into per-block accesses under a map with one
// direct block (file block 0) and a single-indirect table for later blocks.
// Input: an item is taken at a clock edge with start high and busy low.
//   op = load writes entry_index / entry_block into the table; it produces no
//   word and busy stays low, so a new item may follow in the next cycle.
//   op = map takes file_position, byte_count and direct_block.
// Output: each result word is on fs_block, block_offset, segment_length, last
// and range_error for one cycle while valid is high; the receiver cannot stall.
// Sequence of a map item: a range check, division of the position by the block
// size (13 bit-serial steps and a done strobe), a table prefetch, then one
// segment word per cycle from the table memory (read one segment ahead). busy
// stays high until the last word is registered; a map item gives up to
// TABLE_ENTRIES + 1 segments (17 by default). A range error gives a single word
// from the error state, with busy high through the check and error states.
// Configuration: cfg_we / cfg_wdata set the block size (clamped to 16..4096);
// write only while busy is low. Reset sets the block size to 64 and returns
// to idle; the table holds no defined contents until loaded.
module file_range_block_segmenter_unit #(
	parameter int unsigned TABLE_ENTRIES = frbs_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        op,
	input  logic [frbs_pkg::IDX_W-1:0]  entry_index,
	input  logic [frbs_pkg::BLK_W-1:0]  entry_block,
	input  logic [frbs_pkg::POS_W-1:0]  file_position,
	input  logic [frbs_pkg::CNT_W-1:0]  byte_count,
	input  logic [frbs_pkg::BLK_W-1:0]  direct_block,
	input  logic                        cfg_we,
	input  logic [frbs_pkg::BS_W-1:0]   cfg_wdata,
	output logic                        valid,
	output logic [frbs_pkg::BLK_W-1:0]  fs_block,
	output logic [frbs_pkg::OFF_W-1:0]  block_offset,
	output logic [frbs_pkg::LEN_W-1:0]  segment_length,
	output logic                        last,
	output logic                        range_error
);

	localparam int unsigned AW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	// one spare bit so the entry count itself is representable
	localparam int unsigned XW    = ((AW > frbs_pkg::IDX_W) ? AW : frbs_pkg::IDX_W) + 1;
	localparam int unsigned LIM_W = frbs_pkg::BS_W + $clog2(TABLE_ENTRIES + 2);
	localparam int unsigned CMP_W = (LIM_W > frbs_pkg::POS_W + 1) ?
	                                LIM_W : frbs_pkg::POS_W + 1;
	localparam int unsigned QW    = frbs_pkg::QUO_W;
	localparam int unsigned BSW   = frbs_pkg::BS_W;
	localparam int unsigned CW    = frbs_pkg::CNT_W;

	frbs_pkg::state_t state_q, state_next;

	logic [BSW-1:0]               bs_q;
	logic [LIM_W-1:0]             limit_q;
	logic [frbs_pkg::POS_W-1:0]   pos_q;
	logic [CW-1:0]                rem_q;
	logic [frbs_pkg::BLK_W-1:0]   direct_q;
	logic [QW-1:0]                blk_q;
	logic [frbs_pkg::OFF_W-1:0]   off_q;

	logic [frbs_pkg::BLK_W-1:0]   mem [TABLE_ENTRIES];
	logic [frbs_pkg::BLK_W-1:0]   mem_rdata_q;

	logic                         valid_q;
	logic [frbs_pkg::BLK_W-1:0]   fs_block_q;
	logic [frbs_pkg::OFF_W-1:0]   block_offset_q;
	logic [frbs_pkg::LEN_W-1:0]   segment_length_q;
	logic                         last_q;
	logic                         range_error_q;

	logic                         accept;
	logic                         load_ok;
	logic [XW-1:0]                idx_ext;
	logic [CMP_W-1:0]             end_byte;
	logic                         too_far;

	logic                         div_start;
	logic                         div_done;
	logic [QW-1:0]                div_quo;
	logic [frbs_pkg::OFF_W-1:0]   div_rem;

	logic                         rd_en;
	logic [QW-1:0]                rd_sel;
	logic                         emit_seg;
	logic                         emit_err;

	logic [BSW-1:0]               room;
	logic [BSW-1:0]               seg_len;
	logic                         seg_last;

	assign accept = start && !busy;
	assign busy   = (state_q != frbs_pkg::ST_IDLE);

	// table load qualifier
	assign idx_ext = XW'(entry_index);
	assign load_ok = accept && (op == frbs_pkg::OP_LOAD) &&
	                 (idx_ext < XW'(TABLE_ENTRIES));

	// block size register and byte limit of the map
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q    <= frbs_pkg::BS_RESET;
			limit_q <= LIM_W'(frbs_pkg::BS_RESET) * LIM_W'(TABLE_ENTRIES + 1);
		end else begin
			if (cfg_we) begin
				bs_q <= frbs_pkg::clamp_bs(cfg_wdata);
			end
			limit_q <= LIM_W'(bs_q) * LIM_W'(TABLE_ENTRIES + 1);
		end
	end

	// last byte touched by the request, the position itself when empty
	always_comb begin
		if (rem_q == '0) begin
			end_byte = CMP_W'(pos_q);
		end else begin
			end_byte = CMP_W'(pos_q) + CMP_W'(rem_q) - CMP_W'(1);
		end
		too_far = (end_byte >= CMP_W'(limit_q));
	end

	// position divider
	frbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (pos_q),
		.divisor   (bs_q),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			frbs_pkg::ST_IDLE: begin
				if (accept && (op == frbs_pkg::OP_MAP)) state_next = frbs_pkg::ST_CHECK;
			end
			frbs_pkg::ST_CHECK: begin
				state_next = too_far ? frbs_pkg::ST_ERR : frbs_pkg::ST_DIV;
			end
			frbs_pkg::ST_DIV: begin
				if (div_done) state_next = frbs_pkg::ST_PREP;
			end
			frbs_pkg::ST_PREP: begin
				state_next = frbs_pkg::ST_EMIT;
			end
			frbs_pkg::ST_EMIT: begin
				if (seg_last) state_next = frbs_pkg::ST_IDLE;
			end
			frbs_pkg::ST_ERR: begin
				state_next = frbs_pkg::ST_IDLE;
			end
			default: state_next = frbs_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		div_start = 1'b0;
		rd_sel    = blk_q;
		emit_seg  = 1'b0;
		emit_err  = 1'b0;
		case (state_q)
			frbs_pkg::ST_CHECK: begin
				div_start = !too_far;
			end
			frbs_pkg::ST_PREP: begin
				rd_sel = blk_q - QW'(1);
			end
			frbs_pkg::ST_EMIT: begin
				emit_seg = 1'b1;
			end
			frbs_pkg::ST_ERR: begin
				emit_err = 1'b1;
			end
			default: begin
				rd_sel = blk_q;
			end
		endcase
		rd_en = ((state_q == frbs_pkg::ST_PREP) || (state_q == frbs_pkg::ST_EMIT)) &&
		        (rd_sel < QW'(TABLE_ENTRIES));
	end

	// current segment length, bounded by the room left in its block
	always_comb begin
		room = bs_q - BSW'(off_q);
		if (rem_q <= CW'(room)) begin
			seg_len  = BSW'(rem_q);
			seg_last = 1'b1;
		end else begin
			seg_len  = room;
			seg_last = 1'b0;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= frbs_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// request and segment walk registers
	always_ff @(posedge clk) begin
		if (accept && (op == frbs_pkg::OP_MAP)) begin
			pos_q    <= file_position;
			rem_q    <= byte_count;
			direct_q <= direct_block;
		end else if (emit_seg) begin
			rem_q <= rem_q - CW'(seg_len);
			off_q <= '0;
			blk_q <= blk_q + QW'(1);
		end
		if ((state_q == frbs_pkg::ST_DIV) && div_done) begin
			blk_q <= div_quo;
			off_q <= div_rem;
		end
	end

	// indirect table memory, read one segment ahead
	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem[idx_ext[AW-1:0]] <= entry_block;
		end
		if (rd_en) begin
			mem_rdata_q <= mem[rd_sel[AW-1:0]];
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= emit_seg || emit_err;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_err) begin
			fs_block_q       <= '0;
			block_offset_q   <= '0;
			segment_length_q <= '0;
			last_q           <= 1'b1;
			range_error_q    <= 1'b1;
		end else if (emit_seg) begin
			fs_block_q       <= (blk_q == '0) ? direct_q : mem_rdata_q;
			block_offset_q   <= off_q;
			segment_length_q <= frbs_pkg::LEN_W'(seg_len);
			last_q           <= seg_last;
			range_error_q    <= 1'b0;
		end
	end

	assign valid          = valid_q;
	assign fs_block       = fs_block_q;
	assign block_offset   = block_offset_q;
	assign segment_length = segment_length_q;
	assign last           = last_q;
	assign range_error    = range_error_q;

endmodule

### hw/rtl/frbs_div.sv
module frbs_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [frbs_pkg::POS_W-1:0]    dividend,
	input  logic [frbs_pkg::BS_W-1:0]     divisor,
	output logic                          done,
	output logic [frbs_pkg::QUO_W-1:0]    quotient,
	output logic [frbs_pkg::OFF_W-1:0]    remainder
);

	localparam int unsigned QW  = frbs_pkg::QUO_W;
	localparam int unsigned RW  = frbs_pkg::BS_W;
	localparam int unsigned CW  = $clog2(QW + 1);

	logic          run_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [RW-1:0] rem_q;
	logic [QW-1:0] quo_q;
	logic [QW-1:0] low_q;

	logic [RW:0]   trial;
	logic          qbit;
	logic [RW-1:0] rem_next;

	// one restoring step: shift in the next dividend bit and try the subtract
	always_comb begin
		trial = {rem_q, low_q[QW-1]};
		qbit  = (trial >= {1'b0, divisor});
		if (qbit) begin
			rem_next = RW'(trial - {1'b0, divisor});
		end else begin
			rem_next = RW'(trial);
		end
	end

	// control of the iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(QW - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and quotient, the initial remainder holds the top dividend bits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= RW'(dividend[frbs_pkg::POS_W-1:QW]);
			low_q <= dividend[QW-1:0];
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= rem_next;
			low_q <= {low_q[QW-2:0], 1'b0};
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[frbs_pkg::OFF_W-1:0];

endmodule
